/* sv/kbd_diff_pkg.sv */
`timescale 1ns / 1ps

package kbd_diff_pkg;

  // Report geometry
  localparam int KEY_SLOTS  = 6;
  localparam int LANES      = 2 * KEY_SLOTS;
  localparam int LANE_IDX_W = $clog2(LANES);
  localparam int CODE_W     = 8;
  localparam int LEN_W      = 7;

  // Length register limits
  localparam logic [LEN_W-1:0] MIN_REPORT_LEN = 7'd8;
  localparam logic [LEN_W-1:0] LEN_RESET      = 7'd64;

  typedef logic [CODE_W-1:0]                   code_t;
  typedef logic [KEY_SLOTS-1:0][CODE_W-1:0]    key_set_t;
  typedef logic [LANES-1:0][CODE_W-1:0]        lane_codes_t;
  typedef logic [LANES-1:0]                    lane_mask_t;
  typedef logic [LANE_IDX_W-1:0]               lane_idx_t;

  // One key event as it leaves the block
  typedef struct packed {
    code_t keycode;
    logic  released;
    logic  last_event;
  } key_evt_t;

endpackage

/* sv/kbd_diff_lane.sv */
`timescale 1ns / 1ps

module kbd_diff_lane
  import kbd_diff_pkg::*;
(
  input  code_t    code,
  input  key_set_t other_set,
  output logic     hit
);

  // Flag a nonzero code that is absent from the other report
  always_comb begin
    logic found;
    found = 1'b0;
    for (int j = 0; j < KEY_SLOTS; j++) begin
      if (other_set[j] == code) found = 1'b1;
    end
    hit = (code != '0) && !found;
  end

endmodule

/* sv/kbd_diff_merge.sv */
`timescale 1ns / 1ps

module kbd_diff_merge
  import kbd_diff_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  lane_mask_t  lane_mask,
  input  lane_codes_t lane_codes,
  input  logic        out_ready,
  output logic        out_valid,
  output key_evt_t    out_evt,
  output logic        busy
);

  lane_mask_t  mask_r, mask_nxt;
  lane_codes_t codes_r;
  logic        out_valid_r, out_valid_nxt;
  key_evt_t    evt_r, evt_nxt;
  lane_idx_t   pick;
  lane_mask_t  mask_clr;
  logic        advance;

  // Pick the lowest pending lane: releases sit below presses
  always_comb begin
    pick = '0;
    for (int i = LANES - 1; i >= 0; i--) begin
      if (mask_r[i]) pick = lane_idx_t'(i);
    end
    mask_clr = mask_r & (mask_r - lane_mask_t'(1));
  end

  assign advance = (mask_r != '0) && (!out_valid_r || out_ready);

  // Move one pending event into the output register per cycle when it is empty or being taken
  always_comb begin
    mask_nxt      = mask_r;
    out_valid_nxt = out_valid_r;
    evt_nxt       = evt_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (advance) begin
      mask_nxt           = mask_clr;
      out_valid_nxt      = 1'b1;
      evt_nxt.keycode    = codes_r[pick];
      evt_nxt.released   = (pick < lane_idx_t'(KEY_SLOTS));
      evt_nxt.last_event = (mask_clr == '0);
    end
    if (load) mask_nxt = lane_mask;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold codes of the report under work and register the output event
  always_ff @(posedge clk) begin
    evt_r <= evt_nxt;
    if (load) codes_r <= lane_codes;
  end

  assign out_valid = out_valid_r;
  assign out_evt   = evt_r;
  assign busy      = (mask_r != '0);

endmodule

/* sv/keyboard_report_key_diff.sv */
`timescale 1ns / 1ps
// Events of a taken request go from the pending mask to the output register.
// Flow: a report with N events (0 to 12) keeps in_ready low while any are pending;
//   the merge stage drains one event per cycle from its mask unless out_ready stalls it.
// Reset: previous keys cleared to zero, report_length set to 64, no events pending.
// A report taken while report_length is below 8 gives no events and keeps the old keys.

module keyboard_report_key_diff
  import kbd_diff_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [LEN_W-1:0] cfg_report_length,
  input  logic             in_valid,
  output logic             in_ready,
  input  code_t            in_key_slot_0,
  input  code_t            in_key_slot_1,
  input  code_t            in_key_slot_2,
  input  code_t            in_key_slot_3,
  input  code_t            in_key_slot_4,
  input  code_t            in_key_slot_5,
  output logic             out_valid,
  input  logic             out_ready,
  output code_t            out_keycode,
  output logic             out_released,
  output logic             out_last_event
);

  logic [LEN_W-1:0] report_length_r;
  key_set_t         prev_keys_r;
  key_set_t         cur;
  lane_mask_t       lane_mask;
  lane_codes_t      lane_codes;
  key_evt_t         evt;
  logic             busy;
  logic             in_acc;
  logic             decode_en;

  assign cur = {in_key_slot_5, in_key_slot_4, in_key_slot_3,
                in_key_slot_2, in_key_slot_1, in_key_slot_0};

  assign cfg_ready = 1'b1;
  assign in_ready  = !busy;
  assign in_acc    = in_valid && in_ready;
  assign decode_en = (report_length_r >= MIN_REPORT_LEN);

  // Length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      report_length_r <= LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      report_length_r <= cfg_report_length;
    end
  end

  // Replace previous keys on each decoded request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_keys_r <= '0;
    end else if (in_acc && decode_en) begin
      prev_keys_r <= cur;
    end
  end

  // Release lanes check old codes, press lanes check new codes
  for (genvar g = 0; g < KEY_SLOTS; g++) begin : g_lane
    kbd_diff_lane u_rel (
      .code      (prev_keys_r[g]),
      .other_set (cur),
      .hit       (lane_mask[g])
    );
    kbd_diff_lane u_prs (
      .code      (cur[g]),
      .other_set (prev_keys_r),
      .hit       (lane_mask[KEY_SLOTS + g])
    );
    assign lane_codes[g]             = prev_keys_r[g];
    assign lane_codes[KEY_SLOTS + g] = cur[g];
  end

  kbd_diff_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (in_acc && decode_en),
    .lane_mask  (lane_mask),
    .lane_codes (lane_codes),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .out_evt    (evt),
    .busy       (busy)
  );

  assign out_keycode    = evt.keycode;
  assign out_released   = evt.released;
  assign out_last_event = evt.last_event;

  // Checks
  a_disabled_keeps_keys: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !decode_en) |=> $stable(prev_keys_r))
    else $error("previous keys changed while decoding disabled");

  a_keys_follow_report: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && decode_en) |=> (prev_keys_r == $past(cur)))
    else $error("previous keys not replaced by the request");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable({out_keycode, out_released, out_last_event})))
    else $error("event dropped or changed while stalled");

  a_no_accept_midway: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_event) |-> !in_ready)
    else $error("request taken while events still pending");

endmodule

/* tb/sv/kbd_diff_checker.sv */
`timescale 1ns / 1ps

module kbd_diff_checker
  import kbd_diff_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [LEN_W-1:0] cfg_report_length,
  input  logic             in_valid,
  input  logic             in_ready,
  input  code_t            in_key_slot_0,
  input  code_t            in_key_slot_1,
  input  code_t            in_key_slot_2,
  input  code_t            in_key_slot_3,
  input  code_t            in_key_slot_4,
  input  code_t            in_key_slot_5,
  input  logic             out_valid,
  input  logic             out_ready,
  input  code_t            out_keycode,
  input  logic             out_released,
  input  logic             out_last_event,
  output int               mismatches,
  output int               outstanding
);

  logic [LEN_W-1:0] length_reg;
  key_set_t         held_keys;
  key_evt_t         pending_events[$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic bit code_present(code_t code, key_set_t keys);
    bit hit;
    hit = 1'b0;
    for (int j = 0; j < KEY_SLOTS; j++) begin
      if (keys[j] == code) hit = 1'b1;
    end
    return hit;
  endfunction

  // Queue the release events, then the press events, of one request
  function automatic void diff_keys(key_set_t fresh);
    key_evt_t evs[$];
    key_evt_t ev;
    if (length_reg < MIN_REPORT_LEN) return;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      if (held_keys[i] != '0 && !code_present(held_keys[i], fresh)) begin
        ev.keycode    = held_keys[i];
        ev.released   = 1'b1;
        ev.last_event = 1'b0;
        evs.push_back(ev);
      end
    end
    for (int i = 0; i < KEY_SLOTS; i++) begin
      if (fresh[i] != '0 && !code_present(fresh[i], held_keys)) begin
        ev.keycode    = fresh[i];
        ev.released   = 1'b0;
        ev.last_event = 1'b0;
        evs.push_back(ev);
      end
    end
    // Flag the final event of the request
    if (evs.size() > 0) begin
      ev = evs.pop_back();
      ev.last_event = 1'b1;
      evs.push_back(ev);
    end
    foreach (evs[k]) pending_events.push_back(evs[k]);
    held_keys = fresh;
  endfunction

  // Check outputs first: an event taken at this edge belongs to an older request
  always @(posedge clk) begin
    key_evt_t want;
    if (!rst_n) begin
      held_keys  = '0;
      length_reg = LEN_RESET;
      pending_events.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_events.size() == 0) begin
          report_mismatch("event with nothing expected, keycode", out_keycode, 0);
        end else begin
          want = pending_events.pop_front();
          if (out_keycode !== want.keycode)
            report_mismatch("keycode", out_keycode, want.keycode);
          if (out_released !== want.released)
            report_mismatch("released", out_released, want.released);
          if (out_last_event !== want.last_event)
            report_mismatch("last_event", out_last_event, want.last_event);
        end
      end
      if (cfg_valid && cfg_ready) length_reg = cfg_report_length;
      if (in_valid && in_ready) begin
        diff_keys({in_key_slot_5, in_key_slot_4, in_key_slot_3,
                   in_key_slot_2, in_key_slot_1, in_key_slot_0});
      end
    end
    outstanding = pending_events.size();
  end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;
  import kbd_diff_pkg::*;

  localparam int CYCLE_LIMIT    = 700_000;
  localparam int ENABLED_TARGET = 400;
  localparam int DRAIN_CYCLES   = 20;

  logic             clk               = 1'b0;
  logic             rst_n             = 1'b0;
  logic             cfg_valid         = 1'b0;
  logic             cfg_ready;
  logic [LEN_W-1:0] cfg_report_length = '0;
  logic             in_valid          = 1'b0;
  logic             in_ready;
  code_t            in_key_slot_0     = '0;
  code_t            in_key_slot_1     = '0;
  code_t            in_key_slot_2     = '0;
  code_t            in_key_slot_3     = '0;
  code_t            in_key_slot_4     = '0;
  code_t            in_key_slot_5     = '0;
  logic             out_valid;
  logic             out_ready         = 1'b0;
  code_t            out_keycode;
  logic             out_released;
  logic             out_last_event;

  int       mismatches;
  int       outstanding;
  int       cycles       = 0;
  int       stall_left   = 0;
  int       enabled_sent = 0;
  bit       brisk        = 1'b0;
  key_set_t last_sent    = '0;

  logic [LEN_W-1:0] phase_len [8] = '{7'd64, 7'd8, 7'd0, 7'd127, 7'd7, 7'd100, 7'd9, 7'd64};

  keyboard_report_key_diff dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_report_length (cfg_report_length),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_key_slot_0     (in_key_slot_0),
    .in_key_slot_1     (in_key_slot_1),
    .in_key_slot_2     (in_key_slot_2),
    .in_key_slot_3     (in_key_slot_3),
    .in_key_slot_4     (in_key_slot_4),
    .in_key_slot_5     (in_key_slot_5),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_keycode       (out_keycode),
    .out_released      (out_released),
    .out_last_event    (out_last_event)
  );

  kbd_diff_checker u_chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_report_length (cfg_report_length),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_key_slot_0     (in_key_slot_0),
    .in_key_slot_1     (in_key_slot_1),
    .in_key_slot_2     (in_key_slot_2),
    .in_key_slot_3     (in_key_slot_3),
    .in_key_slot_4     (in_key_slot_4),
    .in_key_slot_5     (in_key_slot_5),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_keycode       (out_keycode),
    .out_released      (out_released),
    .out_last_event    (out_last_event),
    .mismatches        (mismatches),
    .outstanding       (outstanding)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Mostly short idle stretches, now and then a long one
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic key_set_t mk(code_t s0, code_t s1, code_t s2,
                                  code_t s3, code_t s4, code_t s5);
    return {s5, s4, s3, s2, s1, s0};
  endfunction

  // Typing: release or press a few keys of the previous request
  function automatic key_set_t next_typing(key_set_t prev);
    key_set_t keys;
    int       r;
    keys = prev;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      r = $urandom_range(0, 99);
      if (r < 15) keys[i] = '0;
      else if (r < 35) keys[i] = code_t'($urandom_range(4, 40));
      else if (r < 38) keys[i] = code_t'($urandom_range(1, 255));
    end
    return keys;
  endfunction

  // Noise: rollover-style repeated codes or arbitrary bytes
  function automatic key_set_t noise_report();
    key_set_t keys;
    code_t    fill;
    fill = code_t'($urandom_range(1, 3));
    for (int i = 0; i < KEY_SLOTS; i++) begin
      keys[i] = ($urandom_range(0, 99) < 30) ? code_t'(0) : code_t'($urandom_range(0, 255));
    end
    if ($urandom_range(0, 99) < 10) keys = {KEY_SLOTS{fill}};
    return keys;
  endfunction

  // Hold the request until taken; valid stays high for back-to-back requests
  task automatic send_report(input key_set_t keys, input int gap);
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid      = 1'b1;
    in_key_slot_0 = keys[0];
    in_key_slot_1 = keys[1];
    in_key_slot_2 = keys[2];
    in_key_slot_3 = keys[3];
    in_key_slot_4 = keys[4];
    in_key_slot_5 = keys[5];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    last_sent = keys;
  endtask

  // Write the length register once the block has gone idle
  task automatic write_length(input logic [LEN_W-1:0] len);
    @(negedge clk);
    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_valid         = 1'b1;
    cfg_report_length = len;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Result side backpressure
  initial begin
    forever begin
      @(negedge clk);
      if (brisk || stall_left == 0) begin
        out_ready = 1'b1;
        if (!brisk && $urandom_range(0, 99) < 30) stall_left = pick_idle();
      end else begin
        out_ready  = 1'b0;
        stall_left = stall_left - 1;
      end
    end
  end

  initial begin
    key_set_t         keys;
    logic [LEN_W-1:0] cur_len;
    int               items;
    int               phase;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: presses, releases, reorders, duplicates, full swap, rollover
    send_report(mk(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), pick_idle());
    send_report(mk(8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), pick_idle());
    send_report(mk(8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), pick_idle());
    send_report(mk(8'h01, 8'h80, 8'hFF, 8'h7F, 8'h55, 8'hAA), pick_idle());
    send_report(mk(8'hAA, 8'h55, 8'h7F, 8'hFF, 8'h80, 8'h01), pick_idle());
    send_report(mk(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), pick_idle());
    send_report(mk(8'h10, 8'h10, 8'h10, 8'h00, 8'h20, 8'h20), pick_idle());
    send_report(mk(8'h00, 8'h00, 8'h10, 8'h00, 8'h00, 8'h00), pick_idle());
    send_report(mk(8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26), pick_idle());
    send_report(mk(8'h11, 8'h12, 8'h13, 8'h14, 8'h15, 8'h16), pick_idle());
    send_report(mk(8'h11, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF), pick_idle());
    send_report(mk(8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01), pick_idle());
    send_report(mk(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), pick_idle());

    // Random phases, each under its own length setting
    phase = 0;
    while (enabled_sent < ENABLED_TARGET) begin
      cur_len = (phase < 8) ? phase_len[phase] : LEN_W'($urandom_range(0, 127));
      brisk   = 1'b0;
      write_length(cur_len);
      brisk = (phase % 3 == 1);
      items = (cur_len >= MIN_REPORT_LEN) ? 60 : 12;
      repeat (items) begin
        keys = ($urandom_range(0, 99) < 75) ? next_typing(last_sent) : noise_report();
        send_report(keys, brisk ? 0 : pick_idle());
        if (cur_len >= MIN_REPORT_LEN) enabled_sent++;
      end
      phase++;
    end

    // Drain and give the verdict
    @(negedge clk);
    in_valid = 1'b0;
    brisk    = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
